### design/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and constants for the reverse Polish stack calculator:
// input op codes, status codes, the decoded command and the result item.
// ----------------------------------------------------------------------------
package rsc_pkg;

    // Data path width of stack entries and operands
    localparam int DATA_W = 32;

    // Stream packing
    localparam int IN_TDATA_W  = 40;   // value[31:0], op[34:32], zero fill
    localparam int IN_TUSER_W  = 1;    // kind
    localparam int OUT_TDATA_W = 40;   // top_value[31:0], depth[34:32], zero fill
    localparam int OUT_TUSER_W = 4;    // status[2:0], result_valid[3]

    // Entries in the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Divider iteration count
    localparam int DIV_STEPS = DATA_W;

    // Raw operator codes on the input
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;

    // Item kind on the input
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_OP   = 1'b1;

    // Decoded operator
    typedef enum logic [2:0] {
        OPC_ADD,
        OPC_SUB,
        OPC_MUL,
        OPC_DIV,
        OPC_ZERO
    } t_opc;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_MANY = 3'd1,
        ST_TOO_FEW  = 3'd2,
        ST_DIV_ZERO = 3'd3,
        ST_SKIPPED  = 3'd4
    } t_status;

    // Command handed from the front to the back
    typedef struct packed {
        logic              is_op;
        t_opc              opc;
        logic [DATA_W-1:0] value;
        logic              last;
    } t_cmd;

    // Result item held in the output register
    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] top_value;
        logic [2:0]        depth;
        logic              result_valid;
        logic              final_res;
    } t_result;

endpackage

### design/rsc_front.sv
// ----------------------------------------------------------------------------
// rsc_front
// Input stage: accepts stream beats, decodes the operator field and holds
// the decoded command until the command queue takes it.
// ----------------------------------------------------------------------------
module rsc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_kind,
    input  logic [rsc_pkg::DATA_W-1:0]      i_value,
    input  logic [2:0]                      i_op,
    input  logic                            i_last,
    output logic                            o_cmd_valid,
    input  logic                            i_cmd_ready,
    output rsc_pkg::t_cmd                   o_cmd
);
    import rsc_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    // Decode the operator, unused codes give zero
    always_comb begin
        n_cmd.is_op = (i_kind == KIND_OP);
        n_cmd.value = i_value;
        n_cmd.last  = i_last;
        case (i_op)
            OP_ADD:  n_cmd.opc = OPC_ADD;
            OP_SUB:  n_cmd.opc = OPC_SUB;
            OP_MUL:  n_cmd.opc = OPC_MUL;
            OP_DIV:  n_cmd.opc = OPC_DIV;
            default: n_cmd.opc = OPC_ZERO;
        endcase
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Hold the decoded beat until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

### design/rsc_queue.sv
// ----------------------------------------------------------------------------
// rsc_queue
// Short command queue between the front and the back so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module rsc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_valid,
    output logic            o_wr_ready,
    input  rsc_pkg::t_cmd   i_wr_cmd,
    output logic            o_rd_valid,
    input  logic            i_rd_ready,
    output rsc_pkg::t_cmd   o_rd_cmd
);
    import rsc_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            wr_en;
    logic            rd_en;

    assign o_wr_ready = (r_count != CW'(QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_cmd   = r_mem[r_rd_ptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    // Store the incoming command
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

### design/rsc_div.sv
// ----------------------------------------------------------------------------
// rsc_div
// Signed 32-bit divider, restoring radix-2, one quotient bit per cycle.
// Truncates toward zero; the most negative value over minus one wraps.
// ----------------------------------------------------------------------------
module rsc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rsc_pkg::DATA_W-1:0]  i_dividend,
    input  logic [rsc_pkg::DATA_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [rsc_pkg::DATA_W-1:0]  o_quot
);
    import rsc_pkg::*;

    localparam int SW = $clog2(DIV_STEPS);

    logic              r_busy;
    logic              r_done;
    logic [SW-1:0]     r_cnt;
    logic [DATA_W:0]   r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    logic              r_neg;
    logic [DATA_W-1:0] abs_a;
    logic [DATA_W-1:0] abs_b;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_sub;
    logic              fits;

    assign abs_a   = i_dividend[DATA_W-1] ? (~i_dividend + DATA_W'(1)) : i_dividend;
    assign abs_b   = i_divisor[DATA_W-1]  ? (~i_divisor + DATA_W'(1))  : i_divisor;
    assign rem_sh  = {r_rem[DATA_W-1:0], r_quo[DATA_W-1]};
    assign fits    = (rem_sh >= {1'b0, r_dvs});
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    assign o_done = r_done;
    assign o_quot = r_neg ? (~r_quo + DATA_W'(1)) : r_quo;

    // Sequence the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SW'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - SW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift in one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= abs_a;
            r_dvs <= abs_b;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub : rem_sh;
            r_quo <= {r_quo[DATA_W-2:0], fits};
        end
    end

endmodule

### design/rsc_back.sv
// ----------------------------------------------------------------------------
// rsc_back
// Execution stage: keeps the operand stack as a shift line with the top in
// entry zero, runs each command, tracks errors and fills the output register.
// ----------------------------------------------------------------------------
module rsc_back #(
    parameter int STACK_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  rsc_pkg::t_cmd       i_cmd,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rsc_pkg::t_result    o_out
);
    import rsc_pkg::*;

    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } t_state;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_PUSH,
        ACT_REPLACE,
        ACT_DROP2
    } t_act;

    t_state            r_state;
    t_state            n_state;
    logic [DATA_W-1:0] r_stack [STACK_DEPTH];
    logic [DATA_W-1:0] n_stack [STACK_DEPTH];
    logic [DW-1:0]     r_depth;
    logic [DW-1:0]     n_depth;
    logic [DW-1:0]     r_pushed;
    logic [DW-1:0]     n_pushed;
    logic              r_err;
    logic              n_err;
    logic [DATA_W-1:0] r_prod;
    logic              r_out_valid;
    t_result           r_out;
    t_result           n_out;

    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] prod_lo;
    logic              out_free;
    logic              fin;
    logic              err_set;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quot;
    logic [DATA_W-1:0] res;
    t_act              act;
    t_status           status;
    logic [DW+2:0]     depth_ext;

    assign rhs      = r_stack[0];
    assign lhs      = r_stack[1];
    assign prod_lo  = lhs * rhs;
    assign out_free = !r_out_valid || i_out_ready;

    rsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (lhs),
        .i_divisor  (rhs),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Choose the action for the command at the head of the queue
    always_comb begin
        n_state   = r_state;
        fin       = 1'b0;
        err_set   = 1'b0;
        div_start = 1'b0;
        res       = '0;
        act       = ACT_NONE;
        status    = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    if (r_err) begin
                        status = ST_SKIPPED;
                        fin    = 1'b1;
                    end else if (!i_cmd.is_op) begin
                        fin = 1'b1;
                        if (r_pushed < DW'(STACK_DEPTH) && r_depth < DW'(STACK_DEPTH)) begin
                            act = ACT_PUSH;
                        end else begin
                            status  = ST_TOO_MANY;
                            err_set = 1'b1;
                        end
                    end else if (r_depth < DW'(2)) begin
                        status  = ST_TOO_FEW;
                        err_set = 1'b1;
                        fin     = 1'b1;
                    end else begin
                        case (i_cmd.opc)
                            OPC_ADD: begin
                                act = ACT_REPLACE;
                                res = lhs + rhs;
                                fin = 1'b1;
                            end
                            OPC_SUB: begin
                                act = ACT_REPLACE;
                                res = lhs - rhs;
                                fin = 1'b1;
                            end
                            OPC_MUL: begin
                                n_state = S_MUL;
                            end
                            OPC_DIV: begin
                                if (rhs == '0) begin
                                    act    = ACT_DROP2;
                                    status = ST_DIV_ZERO;
                                    fin    = 1'b1;
                                end else begin
                                    div_start = 1'b1;
                                    n_state   = S_DIV;
                                end
                            end
                            default: begin
                                act = ACT_REPLACE;
                                fin = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_MUL: begin
                act     = ACT_REPLACE;
                res     = r_prod;
                fin     = 1'b1;
                n_state = S_IDLE;
            end
            S_DIV: begin
                if (div_done) begin
                    act     = ACT_REPLACE;
                    res     = div_quot;
                    fin     = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Shift the stack for push, replace and drop
    always_comb begin
        n_stack  = r_stack;
        n_depth  = r_depth;
        n_pushed = r_pushed;
        case (act)
            ACT_PUSH: begin
                n_stack[0] = i_cmd.value;
                for (int i = 1; i < STACK_DEPTH; i++) begin
                    n_stack[i] = r_stack[i-1];
                end
                n_depth  = r_depth + DW'(1);
                n_pushed = r_pushed + DW'(1);
            end
            ACT_REPLACE: begin
                n_stack[0] = res;
                for (int i = 1; i < STACK_DEPTH - 1; i++) begin
                    n_stack[i] = r_stack[i+1];
                end
                n_depth = r_depth - DW'(1);
            end
            ACT_DROP2: begin
                for (int i = 0; i < STACK_DEPTH - 2; i++) begin
                    n_stack[i] = r_stack[i+2];
                end
                n_depth = r_depth - DW'(2);
            end
            default: begin
            end
        endcase
        n_err = r_err | err_set;
    end

    // Form the result from the state after the item
    always_comb begin
        depth_ext          = {3'b000, n_depth};
        n_out.status       = status;
        n_out.top_value    = (n_depth != '0) ? n_stack[0] : '0;
        n_out.depth        = depth_ext[2:0];
        n_out.result_valid = i_cmd.last && !n_err && (n_depth != '0);
        n_out.final_res    = i_cmd.last;
    end

    assign o_cmd_ready = fin;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Hold state, stack bookkeeping and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_pushed    <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin) begin
                r_out_valid <= 1'b1;
                if (i_cmd.last) begin
                    r_depth  <= '0;
                    r_pushed <= '0;
                    r_err    <= 1'b0;
                end else begin
                    r_depth  <= n_depth;
                    r_pushed <= n_pushed;
                    r_err    <= n_err;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_stack <= n_stack;
            r_out   <= n_out;
        end
        if (r_state == S_IDLE) begin
            r_prod <= prod_lo;
        end
    end

endmodule

### design/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish integer calculator with a small operand stack, fed and
// drained over streaming channels.
// ----------------------------------------------------------------------------
// Input channel s_axis: one beat per token. tuser is the kind (0 number,
// 1 operator), tdata carries the number and the operator code, tlast marks
// the final token of an expression.
// Output channel m_axis: exactly one beat per input beat, in order. tuser
// carries the status and the result-valid flag, tdata the top of stack and
// the depth, tlast echoes the input tlast. After a tlast beat the stack and
// the error flag start over.
// An input beat passes the decode register and the command queue to the execute
// stage, which writes its result beat to the output register; a multiply first
// registers its product, and a divide waits for the divider. Tokens are executed
// one at a time: a multiply or divide finishes before the next token is taken,
// and other tokens run at one token per cycle while the output is not stalled.
// A two-entry command queue sits between the input decode and the execute
// stage, so input beats keep being accepted while a divide runs or the
// output is stalled. When m_axis_tready stays low the output register holds
// its beat, the execute stage waits, and the queue fills before
// s_axis_tready drops. Reset is synchronous and empties the stack.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [rsc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,   // value[31:0], op[34:32]
    input  logic [rsc_pkg::IN_TUSER_W-1:0]       s_axis_tuser,   // kind[0]
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [rsc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // top_value[31:0], depth[34:32]
    output logic [rsc_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,   // status[2:0], result_valid[3]
    output logic                                 m_axis_tlast
);
    import rsc_pkg::*;

    logic    fq_valid;
    logic    fq_ready;
    t_cmd    fq_cmd;
    logic    qb_valid;
    logic    qb_ready;
    t_cmd    qb_cmd;
    t_result out;

    rsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_kind      (s_axis_tuser[0]),
        .i_value     (s_axis_tdata[DATA_W-1:0]),
        .i_op        (s_axis_tdata[DATA_W+2:DATA_W]),
        .i_last      (s_axis_tlast),
        .o_cmd_valid (fq_valid),
        .i_cmd_ready (fq_ready),
        .o_cmd       (fq_cmd)
    );

    rsc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fq_valid),
        .o_wr_ready (fq_ready),
        .i_wr_cmd   (fq_cmd),
        .o_rd_valid (qb_valid),
        .i_rd_ready (qb_ready),
        .o_rd_cmd   (qb_cmd)
    );

    rsc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (qb_valid),
        .o_cmd_ready (qb_ready),
        .i_cmd       (qb_cmd),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (out)
    );

    // Pack the result beat
    assign m_axis_tdata = {{(OUT_TDATA_W - DATA_W - 3){1'b0}}, out.depth, out.top_value};
    assign m_axis_tuser = {out.result_valid, out.status};
    assign m_axis_tlast = out.final_res;

    // A valid final result only closes an expression that saw no error
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out.result_valid |->
            out.final_res && out.status != ST_TOO_MANY && out.status != ST_TOO_FEW
            && out.status != ST_SKIPPED)
        else $error("result_valid on a beat that is not a clean final result");

    // An empty stack reports a zero top
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out.depth == 3'd0 |-> out.top_value == '0)
        else $error("nonzero top_value with empty stack");

    // Too few operands leaves fewer than two entries
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out.status == ST_TOO_FEW |-> out.depth < 3'd2)
        else $error("too-few status with two or more entries");

    // The execute stage only takes a command it is shown
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qb_ready |-> qb_valid)
        else $error("command popped from an empty queue");

endmodule

### test/rpn_stack_calculator_tb.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator_tb
// Self-checking bench for the reverse Polish stack calculator. A built-in
// model of the four-level stack predicts one result beat per accepted token.
// The bench runs directed expressions for wrap, truncation, the -1 result,
// divide overflow, divide by zero and the error paths. It then runs random
// expressions and noise tokens under several idle and stall patterns, plus a
// long output hold-off. Every output beat is compared field by field.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_tb;
    import rsc_pkg::*;

    localparam int STACK_LEVELS = 4;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 40;

    // Operator codes above divide all act as unknown and push zero
    localparam logic [2:0] OP_UNKNOWN_MIN = 3'd4;
    localparam logic [2:0] OP_UNKNOWN_MAX = 3'd7;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic [2:0]  op;
        logic        last;
    } t_calc_token;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // value[31:0], op[34:32]
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // kind[0]
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // top_value[31:0], depth[34:32]
    logic [OUT_TUSER_W-1:0] m_axis_tuser;        // status[2:0], result_valid[3]
    logic                   m_axis_tlast;

    // Calculator state mirrored by the bench
    logic [31:0] calc_stack [STACK_LEVELS];
    int          calc_depth = 0;
    int          calc_pushed = 0;
    logic        calc_err = 1'b0;
    t_result     expected_results [$];

    int idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;
    int hold_end_cycle = 0;
    int tokens_sent = 0;
    int mismatch_count = 0;

    rpn_stack_calculator #(
        .STACK_DEPTH(STACK_LEVELS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Drive output ready: hold off during a requested stretch, else stall at random
    always @(negedge i_clk) begin
        if (cycle_count < hold_end_cycle) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Apply one token to the mirrored stack and form the result beat it causes
    function automatic t_result calc_step(input t_calc_token tok);
        t_result     r;
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] res;
        logic        push_res;
        longint      quo;
        r.status = ST_OK;
        push_res = 1'b1;
        res = '0;
        if (calc_err) begin
            r.status = ST_SKIPPED;
        end else if (tok.kind == KIND_PUSH) begin
            if (calc_pushed < STACK_LEVELS && calc_depth < STACK_LEVELS) begin
                calc_stack[calc_depth] = tok.value;
                calc_depth++;
                calc_pushed++;
            end else begin
                r.status = ST_TOO_MANY;
                calc_err = 1'b1;
            end
        end else if (calc_depth < 2) begin
            r.status = ST_TOO_FEW;
            calc_err = 1'b1;
        end else begin
            rhs = calc_stack[calc_depth-1];
            lhs = calc_stack[calc_depth-2];
            calc_depth -= 2;
            case (tok.op)
                OP_ADD: res = lhs + rhs;
                OP_SUB: res = lhs - rhs;
                OP_MUL: res = lhs * rhs;
                OP_DIV: begin
                    if (rhs == '0) begin
                        push_res = 1'b0;
                        r.status = ST_DIV_ZERO;
                    end else begin
                        // 64-bit quotient truncates toward zero; low word wraps
                        quo = longint'($signed(lhs)) / longint'($signed(rhs));
                        res = quo[31:0];
                    end
                end
                default: res = '0;
            endcase
            if (push_res) begin
                calc_stack[calc_depth] = res;
                calc_depth++;
            end
        end
        r.top_value = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
        r.depth = calc_depth[2:0];
        r.result_valid = tok.last && !calc_err && (calc_depth > 0);
        r.final_res = tok.last;
        // Start over after the closing token
        if (tok.last) begin
            calc_depth = 0;
            calc_pushed = 0;
            calc_err = 1'b0;
        end
        return r;
    endfunction

    // Offer one token, wait until it is accepted, then queue its prediction
    task automatic send_token(input logic kind, input logic [31:0] value,
                              input logic [2:0] op, input logic last);
        t_calc_token tok;
        tok = '{kind: kind, value: value, op: op, last: last};
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_TDATA_W-35){1'b0}}, op, value};
        s_axis_tuser <= kind;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(calc_step(tok));
        tokens_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(4))
            0: return 32'(int'($urandom_range(8)) - 4);
            1: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] rand_op();
        if ($urandom_range(9) < 8) begin
            return 3'($urandom_range(OP_DIV, OP_ADD));
        end
        return 3'($urandom_range(OP_UNKNOWN_MAX, OP_UNKNOWN_MIN));
    endfunction

    task automatic send_noise_token(input logic force_last);
        send_token(1'($urandom), rand_value(), 3'($urandom),
                   force_last || ($urandom_range(5) == 0));
    endtask

    // Send one well-formed expression with up to n_numbers operands
    task automatic run_expression(input int n_numbers);
        logic is_final;
        logic do_push;
        int   steps;
        // Close any open or failed expression first
        if (calc_depth != 0 || calc_pushed != 0 || calc_err) begin
            send_noise_token(1'b1);
        end
        is_final = 1'b0;
        for (steps = 0; steps < 12 && !is_final; steps++) begin
            do_push = (calc_pushed < n_numbers) && (calc_depth < 2 || $urandom_range(1));
            if (do_push) begin
                is_final = (calc_pushed + 1 == n_numbers) && (calc_depth == 0);
                send_token(KIND_PUSH, rand_value(), rand_op(), is_final);
            end else begin
                is_final = (calc_pushed >= n_numbers && calc_depth <= 2) || steps == 11;
                send_token(KIND_OP, rand_value(), rand_op(), is_final);
            end
        end
    endtask

    // Signed wrap on add and truncation toward zero on divide
    task automatic test_wrap_and_truncate();
        send_token(KIND_PUSH, 32'(-7), OP_ADD, 1'b0);
        send_token(KIND_PUSH, 32'd2, OP_ADD, 1'b0);
        send_token(KIND_OP, 32'd0, OP_DIV, 1'b0);
        send_token(KIND_PUSH, 32'hFFFF_FFFF, OP_ADD, 1'b0);
        send_token(KIND_OP, 32'd0, OP_MUL, 1'b0);
        send_token(KIND_PUSH, 32'h7FFF_FFFF, OP_ADD, 1'b0);
        send_token(KIND_OP, 32'hFFFF_FFFF, OP_ADD, 1'b1);
    endtask

    // A computed -1 stays on the stack; most negative over -1 wraps; unknown op
    task automatic test_neg_one_and_overflow();
        send_token(KIND_PUSH, 32'h8000_0000, OP_ADD, 1'b0);
        send_token(KIND_PUSH, 32'd0, OP_ADD, 1'b0);
        send_token(KIND_PUSH, 32'd1, OP_ADD, 1'b0);
        send_token(KIND_OP, 32'd0, OP_SUB, 1'b0);
        send_token(KIND_OP, 32'd0, OP_DIV, 1'b0);
        send_token(KIND_PUSH, 32'd3, OP_ADD, 1'b0);
        send_token(KIND_OP, 32'd0, OP_UNKNOWN_MAX, 1'b1);
    endtask

    // Divide by zero, a fifth number, too few operands and skipped tokens
    task automatic test_error_paths();
        send_token(KIND_PUSH, 32'd9, OP_ADD, 1'b0);
        send_token(KIND_PUSH, 32'd0, OP_ADD, 1'b0);
        send_token(KIND_OP, 32'd0, OP_DIV, 1'b0);
        send_token(KIND_PUSH, 32'd1, OP_ADD, 1'b0);
        send_token(KIND_PUSH, 32'd2, OP_ADD, 1'b0);
        send_token(KIND_PUSH, 32'd3, OP_ADD, 1'b0);
        send_token(KIND_PUSH, 32'd4, OP_ADD, 1'b1);
        send_token(KIND_PUSH, 32'd5, OP_ADD, 1'b0);
        send_token(KIND_OP, 32'd0, OP_MUL, 1'b0);
        send_token(KIND_OP, 32'd0, OP_ADD, 1'b1);
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int count);
        int start_count;
        idle_pct = idle;
        stall_pct = stall;
        start_count = tokens_sent;
        while (tokens_sent - start_count < count) begin
            if ($urandom_range(99) < 85) begin
                run_expression($urandom_range(STACK_LEVELS, 1));
            end else begin
                send_noise_token(1'b0);
            end
        end
    endtask

    // Hold the output off long enough to fill the block, then drain fully
    task automatic test_backpressure();
        int start_count;
        idle_pct = 0;
        stall_pct = 0;
        hold_end_cycle = cycle_count + 300;
        start_count = tokens_sent;
        while (tokens_sent - start_count < 24) begin
            run_expression($urandom_range(STACK_LEVELS, 1));
        end
        // Pause the sender until every result is back
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic report_field(input string field, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field, exp_v, act_v);
        mismatch_count++;
    endtask

    // Compare each output beat with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual tdata 0x%0h tuser 0x%0h",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_axis_tuser[2:0] !== exp_r.status)
                    report_field("status", exp_r.status, m_axis_tuser[2:0]);
                if (m_axis_tdata[31:0] !== exp_r.top_value)
                    report_field("top_value", exp_r.top_value, m_axis_tdata[31:0]);
                if (m_axis_tdata[34:32] !== exp_r.depth)
                    report_field("depth", exp_r.depth, m_axis_tdata[34:32]);
                if (m_axis_tuser[3] !== exp_r.result_valid)
                    report_field("result_valid", exp_r.result_valid, m_axis_tuser[3]);
                if (m_axis_tlast !== exp_r.final_res)
                    report_field("final_res", exp_r.final_res, m_axis_tlast);
            end
        end
    end

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_wrap_and_truncate();
        test_neg_one_and_overflow();
        test_error_paths();
        test_random_traffic(0, 0, 500);
        test_backpressure();
        test_random_traffic(56, 0, 500);
        test_random_traffic(0, 56, 500);
        test_random_traffic(30, 30, 500);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
